### design/tbfm_pkg.sv
// tbfm_pkg: shared types and constants for the triple-buffer frame mailbox
// item codes, result codes, state encoding and control/status structs
// no dependencies
package tbfm_pkg;

  localparam int unsigned WIDTH_W = 15;
  localparam int unsigned PITCH_W = 20;
  localparam int unsigned SIZE_W  = 36;
  localparam int unsigned META_W  = 64;
  localparam int unsigned FMT_W   = 3;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned NSLOTS  = 3;
  // (height-1)*pitch product width
  localparam int unsigned PROD_W  = WIDTH_W + PITCH_W;

  typedef enum logic [1:0] {
    KIND_PUBLISH = 2'd0,
    KIND_ACQUIRE = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IGNORED   = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_PUBLISHED = 3'd2,
    ST_ACQUIRED  = 3'd3,
    ST_NOTHING   = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGBX = 3'd0,
    FMT_RGBA = 3'd1,
    FMT_BGRX = 3'd2,
    FMT_BGRA = 3'd3
  } fmt_e;

  localparam logic [SLOT_W-1:0] PROD_RST = 2'd0;
  localparam logic [SLOT_W-1:0] READY_RST = 2'd1;
  localparam logic [SLOT_W-1:0] CONS_RST = 2'd2;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_CALC   = 2'd1,
    FSM_COMMIT = 2'd2
  } fsm_e;

  typedef struct packed {
    logic load;    // capture the input item
    logic calc;    // register the size product and geometry check
    logic commit;  // update state and fill the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a new result
  } stat_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               source_present;
    logic [WIDTH_W-1:0] width;
    logic [WIDTH_W-1:0] height;
    logic [PITCH_W-1:0] pitch;
    logic [FMT_W-1:0]   format;
    logic [SIZE_W-1:0]  data_size;
    logic [META_W-1:0]  sequence_req;
    logic [META_W-1:0]  pts_ns;
    logic [META_W-1:0]  arrival_ns;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOT_W-1:0]  buffer_index;
    logic [WIDTH_W-1:0] frame_width;
    logic [WIDTH_W-1:0] frame_height;
    logic [FMT_W-1:0]   frame_format;
    logic [META_W-1:0]  frame_sequence;
    logic [META_W-1:0]  frame_pts_ns;
    logic [META_W-1:0]  frame_arrival_ns;
    logic               dropped_stale;
    logic [CNT_W-1:0]   published_total;
    logic [CNT_W-1:0]   rejected_total;
    logic [CNT_W-1:0]   stale_total;
  } result_t;

endpackage

### design/tbfm_if.sv
// tbfm_req_if / tbfm_rsp_if: valid/ready channels for mailbox items and results
// depends on tbfm_pkg for field widths
interface tbfm_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic                          source_present;
  logic [tbfm_pkg::WIDTH_W-1:0]  width;
  logic [tbfm_pkg::WIDTH_W-1:0]  height;
  logic [tbfm_pkg::PITCH_W-1:0]  pitch;
  logic [tbfm_pkg::FMT_W-1:0]    format;
  logic [tbfm_pkg::SIZE_W-1:0]   data_size;
  logic [tbfm_pkg::META_W-1:0]   sequence_req;
  logic [tbfm_pkg::META_W-1:0]   pts_ns;
  logic [tbfm_pkg::META_W-1:0]   arrival_ns;

  modport source (output valid, kind, source_present, width, height, pitch, format,
                  data_size, sequence_req, pts_ns, arrival_ns, input ready);
  modport sink (input valid, kind, source_present, width, height, pitch, format,
                data_size, sequence_req, pts_ns, arrival_ns, output ready);
endinterface

interface tbfm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [tbfm_pkg::SLOT_W-1:0]   buffer_index;
  logic [tbfm_pkg::WIDTH_W-1:0]  frame_width;
  logic [tbfm_pkg::WIDTH_W-1:0]  frame_height;
  logic [tbfm_pkg::FMT_W-1:0]    frame_format;
  logic [tbfm_pkg::META_W-1:0]   frame_sequence;
  logic [tbfm_pkg::META_W-1:0]   frame_pts_ns;
  logic [tbfm_pkg::META_W-1:0]   frame_arrival_ns;
  logic                          dropped_stale;
  logic [tbfm_pkg::CNT_W-1:0]    published_total;
  logic [tbfm_pkg::CNT_W-1:0]    rejected_total;
  logic [tbfm_pkg::CNT_W-1:0]    stale_total;

  modport source (output valid, status, buffer_index, frame_width, frame_height,
                  frame_format, frame_sequence, frame_pts_ns, frame_arrival_ns,
                  dropped_stale, published_total, rejected_total, stale_total,
                  input ready);
  modport sink (input valid, status, buffer_index, frame_width, frame_height,
                frame_format, frame_sequence, frame_pts_ns, frame_arrival_ns,
                dropped_stale, published_total, rejected_total, stale_total,
                output ready);
endinterface

### design/tbfm_ctrl.sv
// tbfm_ctrl: sequencing state machine for the frame mailbox
// issues load / calc / commit commands to tbfm_dp; depends on tbfm_pkg
module tbfm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tbfm_pkg::stat_t stat_i,
  output tbfm_pkg::cmd_t  cmd_o
);
  import tbfm_pkg::*;

  fsm_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) state_d = FSM_CALC;
      end
      FSM_CALC: begin
        state_d = FSM_COMMIT;
      end
      FSM_COMMIT: begin
        if (stat_i.out_free) state_d = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      FSM_CALC: begin
        cmd_o.calc = 1'b1;
      end
      FSM_COMMIT: begin
        cmd_o.commit = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### design/tbfm_dp.sv
// tbfm_dp: mailbox datapath: input register, size check, slot roles,
// slot metadata, counters and the output register; depends on tbfm_pkg
module tbfm_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbfm_pkg::cmd_t    cmd_i,
  output tbfm_pkg::stat_t   stat_o,
  input  tbfm_pkg::item_t   item_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  output tbfm_pkg::result_t res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);
  import tbfm_pkg::*;

  item_t               item_q;
  logic                swz_q;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic                geom_ok_q, geom_ok_d;
  logic [SLOT_W-1:0]   prod_slot_q, prod_slot_d;
  logic [SLOT_W-1:0]   ready_slot_q, ready_slot_d;
  logic [SLOT_W-1:0]   cons_slot_q, cons_slot_d;
  logic                waiting_q, waiting_d;
  logic [CNT_W-1:0]    pub_cnt_q, pub_cnt_d;
  logic [CNT_W-1:0]    rej_cnt_q, rej_cnt_d;
  logic [CNT_W-1:0]    stale_cnt_q, stale_cnt_d;
  logic [WIDTH_W-1:0]  sl_width_q [NSLOTS];
  logic [WIDTH_W-1:0]  sl_height_q [NSLOTS];
  logic [FMT_W-1:0]    sl_fmt_q [NSLOTS];
  logic [META_W-1:0]   sl_seq_q [NSLOTS];
  logic [META_W-1:0]   sl_pts_q [NSLOTS];
  logic [META_W-1:0]   sl_arr_q [NSLOTS];
  logic                slot_we;
  result_t             res_q, res_d;
  logic                res_valid_q;
  logic [WIDTH_W+1:0]  width_bytes;
  logic [SIZE_W-1:0]   need;
  logic                oversize;
  logic [FMT_W-1:0]    fmt_sw;

  assign stat_o.out_free = !res_valid_q || res_ready_i;
  assign res_o           = res_q;
  assign res_valid_o     = res_valid_q;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
  end

  // swizzle config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swz_q <= 1'b0;
    end else if (cfg_we_i) begin
      swz_q <= cfg_wdata_i;
    end
  end

  // geometry check and (height-1)*pitch product
  assign width_bytes = {item_q.width, 2'b00};
  always_comb begin
    geom_ok_d = item_q.source_present && (item_q.width != '0) && (item_q.height != '0)
                && (item_q.pitch >= PITCH_W'(width_bytes));
    prod_d = PROD_W'({{PITCH_W{1'b0}}, item_q.height - WIDTH_W'(1)})
             * PROD_W'({{WIDTH_W{1'b0}}, item_q.pitch});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      prod_q    <= prod_d;
      geom_ok_q <= geom_ok_d;
    end
  end

  // size bound and format swap
  assign need     = SIZE_W'(prod_q) + SIZE_W'(width_bytes);
  assign oversize = (item_q.data_size != '0) && (need > item_q.data_size);

  always_comb begin
    fmt_sw = item_q.format;
    if (swz_q && (item_q.format == FMT_RGBX)) fmt_sw = FMT_BGRX;
    if (swz_q && (item_q.format == FMT_RGBA)) fmt_sw = FMT_BGRA;
  end

  // item decode: next roles, flag, counters and the result
  always_comb begin
    prod_slot_d  = prod_slot_q;
    ready_slot_d = ready_slot_q;
    cons_slot_d  = cons_slot_q;
    waiting_d    = waiting_q;
    pub_cnt_d    = pub_cnt_q;
    rej_cnt_d    = rej_cnt_q;
    stale_cnt_d  = stale_cnt_q;
    slot_we      = 1'b0;
    res_d        = '0;
    res_d.status = ST_IGNORED;
    unique case (kind_e'(item_q.kind))
      KIND_PUBLISH: begin
        if (geom_ok_q) begin
          if (oversize) begin
            rej_cnt_d    = rej_cnt_q + CNT_W'(1);
            res_d.status = ST_REJECTED;
          end else begin
            slot_we                = 1'b1;
            res_d.status           = ST_PUBLISHED;
            res_d.buffer_index     = prod_slot_q;
            res_d.frame_width      = item_q.width;
            res_d.frame_height     = item_q.height;
            res_d.frame_format     = fmt_sw;
            res_d.frame_sequence   = item_q.sequence_req;
            res_d.frame_pts_ns     = item_q.pts_ns;
            res_d.frame_arrival_ns = item_q.arrival_ns;
            res_d.dropped_stale    = waiting_q;
            if (waiting_q) stale_cnt_d = stale_cnt_q + CNT_W'(1);
            prod_slot_d  = ready_slot_q;
            ready_slot_d = prod_slot_q;
            waiting_d    = 1'b1;
            pub_cnt_d    = pub_cnt_q + CNT_W'(1);
          end
        end
      end
      KIND_ACQUIRE: begin
        if (waiting_q) begin
          cons_slot_d            = ready_slot_q;
          ready_slot_d           = cons_slot_q;
          waiting_d              = 1'b0;
          res_d.status           = ST_ACQUIRED;
          res_d.buffer_index     = ready_slot_q;
          res_d.frame_width      = sl_width_q[ready_slot_q];
          res_d.frame_height     = sl_height_q[ready_slot_q];
          res_d.frame_format     = sl_fmt_q[ready_slot_q];
          res_d.frame_sequence   = sl_seq_q[ready_slot_q];
          res_d.frame_pts_ns     = sl_pts_q[ready_slot_q];
          res_d.frame_arrival_ns = sl_arr_q[ready_slot_q];
        end else begin
          res_d.status = ST_NOTHING;
        end
      end
      KIND_CLEAR: begin
        pub_cnt_d    = '0;
        rej_cnt_d    = '0;
        stale_cnt_d  = '0;
        res_d.status = ST_CLEARED;
      end
      KIND_NONE: begin
        res_d.status = ST_IGNORED;
      end
      default: begin
        res_d.status = ST_IGNORED;
      end
    endcase
    res_d.published_total = pub_cnt_d;
    res_d.rejected_total  = rej_cnt_d;
    res_d.stale_total     = stale_cnt_d;
  end

  // roles, flag and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_slot_q  <= PROD_RST;
      ready_slot_q <= READY_RST;
      cons_slot_q  <= CONS_RST;
      waiting_q    <= 1'b0;
      pub_cnt_q    <= '0;
      rej_cnt_q    <= '0;
      stale_cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      prod_slot_q  <= prod_slot_d;
      ready_slot_q <= ready_slot_d;
      cons_slot_q  <= cons_slot_d;
      waiting_q    <= waiting_d;
      pub_cnt_q    <= pub_cnt_d;
      rej_cnt_q    <= rej_cnt_d;
      stale_cnt_q  <= stale_cnt_d;
    end
  end

  // slot metadata, written at the producer slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSLOTS; i++) begin
        sl_width_q[i]  <= '0;
        sl_height_q[i] <= '0;
        sl_fmt_q[i]    <= '0;
        sl_seq_q[i]    <= '0;
        sl_pts_q[i]    <= '0;
        sl_arr_q[i]    <= '0;
      end
    end else if (cmd_i.commit && slot_we) begin
      sl_width_q[prod_slot_q]  <= item_q.width;
      sl_height_q[prod_slot_q] <= item_q.height;
      sl_fmt_q[prod_slot_q]    <= fmt_sw;
      sl_seq_q[prod_slot_q]    <= item_q.sequence_req;
      sl_pts_q[prod_slot_q]    <= item_q.pts_ns;
      sl_arr_q[prod_slot_q]    <= item_q.arrival_ns;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) res_q <= res_d;
  end

endmodule

### design/triple_buffer_frame_mailbox_unit.sv
// An accepted item passes the capture, size-product and commit steps of the
// controller in order, and the result is then held in the output register. Items are
// taken one at a time, each after the last is committed; a held result stalls only the commit step.
// The next item is taken while a finished result still waits in the output register.
// Reset (async, active low) sets slots to producer 0, ready 1, consumer 2, clears
// the new-frame flag, the counters, the slot metadata and swizzle_enable.
module triple_buffer_frame_mailbox_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbfm_req_if.sink   req_i,
  tbfm_rsp_if.source rsp_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);
  import tbfm_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  item_t   item;
  result_t res;

  // pack the incoming item
  always_comb begin
    item.kind           = req_i.kind;
    item.source_present = req_i.source_present;
    item.width          = req_i.width;
    item.height         = req_i.height;
    item.pitch          = req_i.pitch;
    item.format         = req_i.format;
    item.data_size      = req_i.data_size;
    item.sequence_req   = req_i.sequence_req;
    item.pts_ns         = req_i.pts_ns;
    item.arrival_ns     = req_i.arrival_ns;
  end

  tbfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tbfm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res),
    .res_valid_o (rsp_o.valid),
    .res_ready_i (rsp_o.ready)
  );

  // unpack the result
  assign rsp_o.status           = res.status;
  assign rsp_o.buffer_index     = res.buffer_index;
  assign rsp_o.frame_width      = res.frame_width;
  assign rsp_o.frame_height     = res.frame_height;
  assign rsp_o.frame_format     = res.frame_format;
  assign rsp_o.frame_sequence   = res.frame_sequence;
  assign rsp_o.frame_pts_ns     = res.frame_pts_ns;
  assign rsp_o.frame_arrival_ns = res.frame_arrival_ns;
  assign rsp_o.dropped_stale    = res.dropped_stale;
  assign rsp_o.published_total  = res.published_total;
  assign rsp_o.rejected_total   = res.rejected_total;
  assign rsp_o.stale_total      = res.stale_total;

endmodule

### design/tbfm_checker.sv
// tbfm_checker: port-level assertions for the frame mailbox, bound to the top
// depends on tbfm_pkg for status codes and slot width
module tbfm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [2:0]                  status_i,
  input logic [tbfm_pkg::SLOT_W-1:0] buffer_index_i,
  input logic                        dropped_stale_i
);
  import tbfm_pkg::*;

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // controller takes one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while another is in progress");

  // only known status codes and slot numbers leave the block
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i <= ST_CLEARED) && (buffer_index_i <= SLOT_W'(NSLOTS - 1)))
    else $error("bad status or slot index");

  // stale drop is reported only with a publish
  a_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dropped_stale_i |-> status_i == ST_PUBLISHED)
    else $error("stale drop on a non-publish result");

endmodule

bind triple_buffer_frame_mailbox_unit tbfm_checker u_tbfm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .buffer_index_i  (rsp_o.buffer_index),
  .dropped_stale_i (rsp_o.dropped_stale)
);
